@@ hdl/wsbd_pkg.sv @@
// shared types and constants for the windowed scan and brute-force detector
// no dependencies
`default_nettype none
package wsbd_pkg;
	localparam int unsigned DEF_HISTORY_DEPTH = 256;
	localparam int unsigned DEF_TRACKED_PORTS = 16;
	localparam int unsigned QUEUE_DEPTH       = 2;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned PORT_W  = 16;
	localparam int unsigned WIN_W   = 16;
	localparam int unsigned BRUTE_W = 9;
	localparam int unsigned SCAN_W  = 5;
	localparam int unsigned PKT_W   = TIME_W + 2 * ADDR_W + PORT_W;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [WIN_W-1:0]   RST_WINDOW = WIN_W'(10);
	localparam logic [BRUTE_W-1:0] RST_BRUTE  = BRUTE_W'(4);
	localparam logic [SCAN_W-1:0]  RST_SCAN   = SCAN_W'(5);
	localparam logic [PORT_W-1:0]  RST_PORT   = PORT_W'(22);

	localparam logic [2:0] SEV_BRUTE = 3'd4;
	localparam logic [2:0] SEV_SCAN  = 3'd3;
	localparam logic [2:0] SEV_NONE  = 3'd0;
	localparam logic       KIND_BRUTE = 1'b0;
	localparam logic       KIND_SCAN  = 1'b1;

	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_BRUTE  = 2'd1,
		REG_SCAN   = 2'd2,
		REG_PORT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PORT_W-1:0] destination_port;
		logic [ADDR_W-1:0] source_addr_low;
		logic [ADDR_W-1:0] source_addr_high;
		logic [TIME_W-1:0] arrival_seconds;
	} pkt_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_seconds;
		logic [BRUTE_W-1:0] brute_threshold;
		logic [SCAN_W-1:0]  scan_threshold;
		logic [PORT_W-1:0]  watched_port;
	} cfg_t;

	typedef struct packed {
		logic       alert;
		logic       threat_kind;
		logic [2:0] severity_level;
		logic       confirmed_flag;
	} res_t;
endpackage
`default_nettype wire

@@ hdl/windowed_scan_and_brute_force_detector.sv @@
// top level of the windowed scan and brute-force detector
// depends on wsbd_pkg, wsbd_cfg, wsbd_fifo, wsbd_scan
//
// channel   dir  signals                              content
// s_axis    in   s_tvalid s_tready s_tdata            one packet per transfer
// m_axis    out  m_tvalid m_tready m_tdata m_tuser    one verdict per packet
// apb       in   psel penable pwrite paddr pwdata ... four config registers
//
// in the scan engine each packet is popped, written into the history, then every
// history entry is read in turn from the memory's read port, followed by a drain
// and a decision state. a two-entry queue takes packets while the engine is busy;
// the verdict register holds a result while m_tready is low, and the engine stalls
// in its decision state only while that register is full and m_tready is low.
// reset empties the history at once through a fill count; no clearing pass.
`default_nettype none
module windowed_scan_and_brute_force_detector #(
	parameter int unsigned HISTORY_DEPTH = wsbd_pkg::DEF_HISTORY_DEPTH,
	parameter int unsigned TRACKED_PORTS = wsbd_pkg::DEF_TRACKED_PORTS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// arrival_seconds, source_addr_high, source_addr_low, destination_port
	input  wire logic [wsbd_pkg::PKT_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// alert, severity_level, confirmed_flag, zero pad
	output logic      [7:0]                   m_tdata,
	// threat_kind
	output logic      [0:0]                   m_tuser,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wsbd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wsbd_pkg::PDATA_W-1:0] pwdata,
	output logic      [wsbd_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import wsbd_pkg::*;

	cfg_t cfg;
	pkt_t q_pkt;
	logic q_valid, q_pop;
	res_t res;

	wsbd_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	wsbd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_pkt(pkt_t'(s_tdata)), .out_valid(q_valid), .out_pop(q_pop), .out_pkt(q_pkt)
	);

	wsbd_scan #(.HISTORY_DEPTH(HISTORY_DEPTH), .TRACKED_PORTS(TRACKED_PORTS)) u_scan (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pkt_valid(q_valid), .pkt_pop(q_pop),
		.pkt(q_pkt), .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {3'b000, res.confirmed_flag, res.severity_level, res.alert};
	assign m_tuser = res.threat_kind;
endmodule
`default_nettype wire

@@ hdl/wsbd_cfg.sv @@
// apb register file for detector thresholds, window and watched port
// depends on wsbd_pkg
`default_nettype none
module wsbd_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wsbd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wsbd_pkg::PDATA_W-1:0] pwdata,
	output logic      [wsbd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output wsbd_pkg::cfg_t                   cfg
);
	import wsbd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds  <= RST_WINDOW;
			cfg_q.brute_threshold <= RST_BRUTE;
			cfg_q.scan_threshold  <= RST_SCAN;
			cfg_q.watched_port    <= RST_PORT;
		end else if (wr_en) begin
			unique case (idx)
				REG_WINDOW: cfg_q.window_seconds  <= pwdata[WIN_W-1:0];
				REG_BRUTE:  cfg_q.brute_threshold <= pwdata[BRUTE_W-1:0];
				REG_SCAN:   cfg_q.scan_threshold  <= pwdata[SCAN_W-1:0];
				REG_PORT:   cfg_q.watched_port    <= pwdata[PORT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WINDOW: prdata = PDATA_W'(cfg_q.window_seconds);
			REG_BRUTE:  prdata = PDATA_W'(cfg_q.brute_threshold);
			REG_SCAN:   prdata = PDATA_W'(cfg_q.scan_threshold);
			REG_PORT:   prdata = PDATA_W'(cfg_q.watched_port);
			default:    prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/wsbd_fifo.sv @@
// front queue: accepts packet transfers and holds them for the scan engine
// depends on wsbd_pkg
`default_nettype none
module wsbd_fifo #(
	parameter int unsigned DEPTH = wsbd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire wsbd_pkg::pkt_t in_pkt,
	output logic                out_valid,
	input  wire logic           out_pop,
	output wsbd_pkg::pkt_t      out_pkt
);
	import wsbd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pkt_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_pkt   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/wsbd_scan.sv @@
// back end: history ring memory, sequential window scan and alert decision
// depends on wsbd_pkg
`default_nettype none
module wsbd_scan #(
	parameter int unsigned HISTORY_DEPTH = wsbd_pkg::DEF_HISTORY_DEPTH,
	parameter int unsigned TRACKED_PORTS = wsbd_pkg::DEF_TRACKED_PORTS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wsbd_pkg::cfg_t cfg,
	input  wire logic           pkt_valid,
	output logic                pkt_pop,
	input  wire wsbd_pkg::pkt_t pkt,
	output logic                res_valid,
	input  wire logic           res_ready,
	output wsbd_pkg::res_t      res
);
	import wsbd_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned NW = $clog2(TRACKED_PORTS + 1);
	localparam int unsigned HC = (FW > BRUTE_W) ? FW : BRUTE_W;
	localparam int unsigned NC = (NW > SCAN_W) ? NW : SCAN_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WR   = 5'b00010,
		ST_RD   = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_DEC  = 5'b10000
	} state_t;

	state_t            state_q;
	pkt_t              pkt_q;
	pkt_t              mem [HISTORY_DEPTH];
	pkt_t              rdata_s1;
	logic              rdv_s1, inr_s1;
	logic [AW-1:0]     slot_q, rd_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     hits_q;
	logic [NW-1:0]     nseen_q;
	logic [PORT_W-1:0] seen_q [TRACKED_PORTS];
	res_t              res_q;
	logic              res_valid_q;

	logic              newer, in_win, same_src, elig, found, is_hit;
	logic [TIME_W-1:0] age;
	logic              brute, scan;
	res_t              res_d;

	always_comb begin
		newer    = (pkt_q.arrival_seconds < rdata_s1.arrival_seconds);
		age      = pkt_q.arrival_seconds - rdata_s1.arrival_seconds;
		in_win   = newer || (age <= TIME_W'(cfg.window_seconds));
		same_src = (rdata_s1.source_addr_high == pkt_q.source_addr_high) &&
			(rdata_s1.source_addr_low == pkt_q.source_addr_low);
		elig     = rdv_s1 && inr_s1 && (rdata_s1.arrival_seconds != '0) &&
			in_win && same_src;
		is_hit   = (rdata_s1.destination_port == cfg.watched_port);
		found    = 1'b0;
		for (int p = 0; p < TRACKED_PORTS; p++) begin
			if ((NW'(p) < nseen_q) && (seen_q[p] == rdata_s1.destination_port)) begin
				found = 1'b1;
			end
		end
	end

	always_comb begin
		brute = (HC'(hits_q) >= HC'(cfg.brute_threshold));
		scan  = (NC'(nseen_q) >= NC'(cfg.scan_threshold));
		priority if (brute) begin
			res_d = '{alert: 1'b1, threat_kind: KIND_BRUTE, severity_level: SEV_BRUTE,
				confirmed_flag: 1'b1};
		end else if (scan) begin
			res_d = '{alert: 1'b1, threat_kind: KIND_SCAN, severity_level: SEV_SCAN,
				confirmed_flag: 1'b0};
		end else begin
			res_d = '{alert: 1'b0, threat_kind: KIND_BRUTE, severity_level: SEV_NONE,
				confirmed_flag: 1'b0};
		end
	end

	assign pkt_pop   = (state_q == ST_IDLE) && pkt_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			mem[slot_q] <= pkt_q;
		end
		rdata_s1 <= mem[rd_q];
		inr_s1   <= (FW'(rd_q) < fill_q);
		if (pkt_pop) begin
			pkt_q <= pkt;
		end
		if (state_q == ST_DEC && (!res_valid_q || res_ready)) begin
			res_q <= res_d;
		end
		if (elig && !found && (nseen_q < NW'(TRACKED_PORTS))) begin
			for (int p = 0; p < TRACKED_PORTS; p++) begin
				if (NW'(p) == nseen_q) begin
					seen_q[p] <= rdata_s1.destination_port;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			rd_q        <= '0;
			rdv_s1      <= 1'b0;
			hits_q      <= '0;
			nseen_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_RD);
			if (state_q == ST_DEC && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (elig) begin
				if (is_hit) begin
					hits_q <= hits_q + 1'b1;
				end
				if (!found && (nseen_q < NW'(TRACKED_PORTS))) begin
					nseen_q <= nseen_q + 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pkt_valid) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					slot_q  <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					if (fill_q != FW'(HISTORY_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					rd_q    <= '0;
					hits_q  <= '0;
					nseen_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					rd_q <= rd_q + 1'b1;
					if (rd_q == AW'(HISTORY_DEPTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_DEC;
				ST_DEC: begin
					if (!res_valid_q || res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HISTORY_DEPTH)) else $error("fill count beyond history depth");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nseen_q <= NW'(TRACKED_PORTS)) else $error("distinct count beyond tracked ports");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |=> (rd_q == '0 && hits_q == '0 && nseen_q == '0))
		else $error("scan did not start clean");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && res_valid_q && !res_ready) |=> (state_q == ST_DEC))
		else $error("result dropped while output stalled");
endmodule
`default_nettype wire
